@@ rtl/core/vn_pkg.sv @@
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normalizer
// Holds the per-stage control bundle and the fixed-point format constants.
// ----------------------------------------------------------------------------
package vn_pkg;

  // Default width of one input component.
  localparam int COMPONENT_BITS_DEF = 16;

  // Output format: signed Q1.14 in 16 bits.
  localparam int OUT_BITS  = 16;
  localparam int FRAC_BITS = 14;

  // Quotient bits before rounding; the magnitude never exceeds one.
  localparam int Q_BITS = FRAC_BITS + 1;

  // The squared length is scaled by 2^ROOT_PAD before the root is taken, and
  // each component by 2^NUM_SHIFT before the division.
  localparam int ROOT_PAD  = 2 * (FRAC_BITS + 1);
  localparam int NUM_SHIFT = 2 * FRAC_BITS + 1;

  localparam logic [Q_BITS-1:0] UNIT_ONE = Q_BITS'(1) << FRAC_BITS;

  // Control bundle that travels with every item through the pipeline.
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } vn_ctl_t;

endpackage

@@ rtl/core/vn_square.sv @@
// ----------------------------------------------------------------------------
// vn_square: magnitude, squaring and sum of squares
// Three register stages: absolute value, one square per lane, then the sum.
// ----------------------------------------------------------------------------
module vn_square #(
  parameter int N = vn_pkg::COMPONENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][N-1:0]      comp,
  output vn_pkg::vn_ctl_t        ctl_out,
  output logic [2:0][N-1:0]      mag_out,
  output logic [2*N-1:0]         sum_out
);

  vn_pkg::vn_ctl_t       ctl_a, ctl_b;
  logic [2:0][N-1:0]     mag_a, mag_b;
  logic [2:0][2*N-1:0]   sq_b;
  logic [2:0][N-1:0]     mag_in;
  logic [2:0]            neg_in;

  // Split each two's complement component into sign and magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = comp[i][N-1];
      mag_in[i] = neg_in[i] ? (~comp[i] + N'(1)) : comp[i];
    end
  end

  // Control registers of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_b   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_a.valid <= in_valid;
      ctl_a.zero  <= (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
      ctl_a.neg   <= neg_in;
      ctl_b       <= ctl_a;
      ctl_out     <= ctl_b;
    end
  end

  // Data registers: magnitudes, squares, sum.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= mag_in;
      mag_b <= mag_a;
      mag_out <= mag_b;
      for (int i = 0; i < 3; i++) begin
        sq_b[i] <= {{N{1'b0}}, mag_a[i]} * {{N{1'b0}}, mag_a[i]};
      end
      sum_out <= sq_b[0] + sq_b[1] + sq_b[2];
    end
  end

endmodule

@@ rtl/core/vn_sqrt.sv @@
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// One root bit per register stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module vn_sqrt #(
  parameter int N = vn_pkg::COMPONENT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  vn_pkg::vn_ctl_t      ctl_in,
  input  logic [2:0][N-1:0]    mag_in,
  input  logic [2*N-1:0]       sum_in,
  output vn_pkg::vn_ctl_t      ctl_out,
  output logic [2:0][N-1:0]    mag_out,
  output logic [N+vn_pkg::ROOT_PAD/2-1:0] root_out
);

  localparam int RW  = 2 * N + vn_pkg::ROOT_PAD;
  localparam int RB  = RW / 2;
  localparam int RMW = RB + 2;

  vn_pkg::vn_ctl_t      ctl_s  [RB+1];
  logic [2:0][N-1:0]    mag_s  [RB+1];
  logic [RW-1:0]        rad_s  [RB+1];
  logic [RMW-1:0]       rem_s  [RB+1];
  logic [RB-1:0]        root_s [RB+1];

  // Stage zero is the incoming item with the padded radicand.
  assign ctl_s[0]  = ctl_in;
  assign mag_s[0]  = mag_in;
  assign rad_s[0]  = {sum_in, {vn_pkg::ROOT_PAD{1'b0}}};
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < RB; k++) begin : g_step
    localparam int POS = 2 * (RB - 1 - k);
    logic [RMW-1:0] shifted, trial;

    // Bring down the next bit pair and try the next root bit.
    always_comb begin
      shifted = {rem_s[k][RMW-3:0], rad_s[k][POS+1:POS]};
      trial   = {root_s[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1] <= '0;
      end else if (en) begin
        ctl_s[k+1] <= ctl_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_s[k+1] <= mag_s[k];
        rad_s[k+1] <= rad_s[k];
        if (shifted >= trial) begin
          rem_s[k+1]  <= shifted - trial;
          root_s[k+1] <= {root_s[k][RB-2:0], 1'b1};
        end else begin
          rem_s[k+1]  <= shifted;
          root_s[k+1] <= {root_s[k][RB-2:0], 1'b0};
        end
      end
    end
  end

  assign ctl_out  = ctl_s[RB];
  assign mag_out  = mag_s[RB];
  assign root_out = root_s[RB];

endmodule

@@ rtl/core/vn_div.sv @@
// ----------------------------------------------------------------------------
// vn_div: pipelined three-lane divider with rounding and output format
// One quotient bit per stage for all lanes, then a rounding stage.
// ----------------------------------------------------------------------------
module vn_div #(
  parameter int N = vn_pkg::COMPONENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  vn_pkg::vn_ctl_t                   ctl_in,
  input  logic [2:0][N-1:0]                 mag_in,
  input  logic [N+vn_pkg::ROOT_PAD/2-1:0]   root_in,
  output vn_pkg::vn_ctl_t                   ctl_out,
  output logic [2:0][vn_pkg::OUT_BITS-1:0]  unit_out
);

  localparam int RB = N + vn_pkg::ROOT_PAD / 2;
  localparam int NW = N + vn_pkg::NUM_SHIFT;
  localparam int Q  = vn_pkg::Q_BITS;

  vn_pkg::vn_ctl_t            ctl_s  [Q+1];
  logic [2:0][NW-1:0]         rem_s  [Q+1];
  logic [2:0][Q-1:0]          quo_s  [Q+1];
  logic [RB-1:0]              root_s [Q+1];

  // Stage zero holds the scaled numerators.
  always_comb begin
    ctl_s[0]  = ctl_in;
    root_s[0] = root_in;
    quo_s[0]  = '0;
    for (int i = 0; i < 3; i++) begin
      rem_s[0][i] = NW'(mag_in[i]) << vn_pkg::NUM_SHIFT;
    end
  end

  for (genvar j = 0; j < Q; j++) begin : g_step
    localparam int B = Q - 1 - j;
    logic [NW-1:0] dsh;

    assign dsh = NW'(root_s[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[j+1] <= '0;
      end else if (en) begin
        ctl_s[j+1] <= ctl_s[j];
      end
    end

    // Restoring subtract of the shifted divisor, one bit per lane.
    always_ff @(posedge clk) begin
      if (en) begin
        root_s[j+1] <= root_s[j];
        for (int i = 0; i < 3; i++) begin
          if (rem_s[j][i] >= dsh) begin
            rem_s[j+1][i] <= rem_s[j][i] - dsh;
            quo_s[j+1][i] <= quo_s[j][i] | (Q'(1) << B);
          end else begin
            rem_s[j+1][i] <= rem_s[j][i];
            quo_s[j+1][i] <= quo_s[j][i];
          end
        end
      end
    end
  end

  logic [2:0][vn_pkg::OUT_BITS-1:0] unit_next;

  // Round half away from zero, clamp to one, apply the sign; a zero vector gives zero.
  always_comb begin
    logic [Q-1:0] qr;
    logic         up;
    for (int i = 0; i < 3; i++) begin
      up = {rem_s[Q][i], 1'b0} >= (NW+1)'(root_s[Q]);
      qr = quo_s[Q][i] + Q'(up);
      if (qr > vn_pkg::UNIT_ONE) begin
        qr = vn_pkg::UNIT_ONE;
      end
      if (ctl_s[Q].zero) begin
        unit_next[i] = '0;
      end else if (ctl_s[Q].neg[i]) begin
        unit_next[i] = -vn_pkg::OUT_BITS'(qr);
      end else begin
        unit_next[i] = vn_pkg::OUT_BITS'(qr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_s[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_out <= unit_next;
    end
  end

endmodule

@@ rtl/core/vector3_normalize.sv @@
// Throughput: one vector per cycle while the output is not stalled; the pipeline
// length is set by the square root (one root bit per stage) and the divider
// (one quotient bit per stage).
// A stall at the output holds every stage; nothing is lost or repeated.
// Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// vector3_normalize: 3D vector to unit vector in signed Q1.14
// Squares, square root and three-lane division in one flowing pipeline.
// ----------------------------------------------------------------------------
module vector3_normalize #(
  parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COMPONENT_BITS-1:0]   in_x,
  input  logic signed [COMPONENT_BITS-1:0]   in_y,
  input  logic signed [COMPONENT_BITS-1:0]   in_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vn_pkg::OUT_BITS-1:0] unit_x,
  output logic signed [vn_pkg::OUT_BITS-1:0] unit_y,
  output logic signed [vn_pkg::OUT_BITS-1:0] unit_z,
  output logic                               zero_length
);

  localparam int N  = COMPONENT_BITS;
  localparam int RB = N + vn_pkg::ROOT_PAD / 2;

  logic                             en;
  vn_pkg::vn_ctl_t                  ctl_sq, ctl_rt, ctl_dv;
  logic [2:0][N-1:0]                mag_sq, mag_rt;
  logic [2*N-1:0]                   sum_sq;
  logic [RB-1:0]                    root;
  logic [2:0][vn_pkg::OUT_BITS-1:0] unit;

  // The whole pipeline advances unless a finished result is blocked.
  assign en       = !ctl_dv.valid || out_ready;
  assign in_ready = en;

  vn_square #(.N(N)) u_square (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .comp     ({in_z, in_y, in_x}),
    .ctl_out  (ctl_sq),
    .mag_out  (mag_sq),
    .sum_out  (sum_sq)
  );

  vn_sqrt #(.N(N)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl_sq),
    .mag_in   (mag_sq),
    .sum_in   (sum_sq),
    .ctl_out  (ctl_rt),
    .mag_out  (mag_rt),
    .root_out (root)
  );

  vn_div #(.N(N)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl_rt),
    .mag_in   (mag_rt),
    .root_in  (root),
    .ctl_out  (ctl_dv),
    .unit_out (unit)
  );

  assign out_valid   = ctl_dv.valid;
  assign zero_length = ctl_dv.zero;
  assign unit_x      = unit[0];
  assign unit_y      = unit[1];
  assign unit_z      = unit[2];

endmodule

@@ rtl/core/vn_checker.sv @@
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for the vector normalizer
// Watches the handshakes and the output range, bound to the top level.
// ----------------------------------------------------------------------------
module vn_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [vn_pkg::OUT_BITS-1:0] unit_x,
  input logic signed [vn_pkg::OUT_BITS-1:0] unit_y,
  input logic signed [vn_pkg::OUT_BITS-1:0] unit_z,
  input logic                               zero_length
);

  localparam logic signed [vn_pkg::OUT_BITS-1:0] ONE =
    vn_pkg::OUT_BITS'(vn_pkg::UNIT_ONE);

  // A blocked result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y)
      && $stable(unit_z) && $stable(zero_length))
    else $error("result changed while stalled");

  // The input side is only held back by a blocked result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output flow");

  // A zero vector gives zero outputs.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
    else $error("zero vector with nonzero output");

  // Every component stays within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_x <= ONE && unit_x >= -ONE && unit_y <= ONE
      && unit_y >= -ONE && unit_z <= ONE && unit_z >= -ONE)
    else $error("output component out of range");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .unit_x      (unit_x),
  .unit_y      (unit_y),
  .unit_z      (unit_z),
  .zero_length (zero_length)
);
